### rtl/core/nbcfg_pkg.sv
// Shared types, codes and reset tables for the northbridge configuration block.
`timescale 1ns / 1ps

package nbcfg_pkg;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic       ROUTE_EXT     = 1'b0;
   localparam logic       ROUTE_INT     = 1'b1;
   localparam logic [1:0] WROUTE_EXT     = 2'd0;
   localparam logic [1:0] WROUTE_INT     = 2'd1;
   localparam logic [1:0] WROUTE_DISCARD = 2'd2;

   localparam logic [7:0] REG_STATUS_HI = 8'h07;
   localparam logic [7:0] REG_SHADOW_CD = 8'h5d;
   localparam logic [7:0] REG_SHADOW_EF = 8'h5f;
   localparam logic [7:0] REG_SMRAM     = 8'h65;
   localparam logic [7:0] STATUS_W1C_MASK = 8'hf9;
   localparam logic [2:0] FUNC_ZERO = 3'd0;

   typedef struct packed {
      logic [19:0] mem_address;
      logic        in_smm;
      logic [7:0]  write_data;
      logic [7:0]  register_index;
      logic [2:0]  function_number;
      logic [1:0]  operation;
   } req_type;

   typedef struct packed {
      logic [1:0] write_route;
      logic       read_route;
      logic       region_claimed;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic [7:0] idx;
      logic [7:0] data;
   } wr_type;

   function automatic logic [7:0] cfg_default(input logic [7:0] idx);
      logic [7:0] val;
      begin
         case (idx)
            8'h00: val = 8'h60;
            8'h01: val = 8'h10;
            8'h02: val = 8'h91;
            8'h03: val = 8'h88;
            8'h07: val = 8'h02;
            8'h08: val = 8'h01;
            8'h0b: val = 8'h06;
            default: val = 8'h00;
         endcase
         return val;
      end
   endfunction

   function automatic logic cfg_writable(input logic [7:0] idx);
      logic ok;
      begin
         ok = 1'b1;
         if (idx <= 8'h03) ok = 1'b0;
         if (idx == 8'h06) ok = 1'b0;
         if (idx >= 8'h08 && idx <= 8'h0b) ok = 1'b0;
         if (idx >= 8'h0e && idx <= 8'h3f) ok = 1'b0;
         return ok;
      end
   endfunction

endpackage

### rtl/core/nbcfg_space.sv
// Configuration byte store with reset-value tracking, write forwarding and shadow copies.
`timescale 1ns / 1ps

module nbcfg_space
   import nbcfg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       rd_en,
   input  logic [7:0] rd_idx,
   input  wr_type     wr,
   output logic [7:0] rd_byte,
   output logic [7:0] shadow_cd,
   output logic [7:0] shadow_ef,
   output logic [7:0] smram_ctl
);

   logic [7:0] cfg_mem [256];
   logic [7:0] mem_q_ff;
   logic       valid_ff [256];
   logic       valid_q_ff;
   logic       valid_q_in;
   logic [7:0] idx_ff;
   logic       fwd_hit_ff;
   logic       fwd_hit_in;
   logic [7:0] fwd_val_ff;
   logic [7:0] shadow_cd_ff, shadow_cd_in;
   logic [7:0] shadow_ef_ff, shadow_ef_in;
   logic [7:0] smram_ff, smram_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cfg_mem[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         mem_q_ff <= cfg_mem[rd_idx];
         idx_ff <= rd_idx;
         fwd_val_ff <= wr.data;
      end
   end

   assign valid_q_in = valid_ff[rd_idx];
   assign fwd_hit_in = wr.en && (wr.idx == rd_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 256; i++) begin
            valid_ff[i] <= 1'b0;
         end
         valid_q_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.idx] <= 1'b1;
         end
         if (rd_en) begin
            valid_q_ff <= valid_q_in;
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_comb begin
      shadow_cd_in = shadow_cd_ff;
      shadow_ef_in = shadow_ef_ff;
      smram_in = smram_ff;
      if (wr.en && wr.idx == REG_SHADOW_CD) shadow_cd_in = wr.data;
      if (wr.en && wr.idx == REG_SHADOW_EF) shadow_ef_in = wr.data;
      if (wr.en && wr.idx == REG_SMRAM) smram_in = wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_cd_ff <= cfg_default(REG_SHADOW_CD);
         shadow_ef_ff <= cfg_default(REG_SHADOW_EF);
         smram_ff <= cfg_default(REG_SMRAM);
      end else begin
         shadow_cd_ff <= shadow_cd_in;
         shadow_ef_ff <= shadow_ef_in;
         smram_ff <= smram_in;
      end
   end

   assign rd_byte = fwd_hit_ff ? fwd_val_ff :
                    (valid_q_ff ? mem_q_ff : cfg_default(idx_ff));
   assign shadow_cd = shadow_cd_ff;
   assign shadow_ef = shadow_ef_ff;
   assign smram_ctl = smram_ff;

endmodule

### rtl/core/nbcfg_decode.sv
// Access decode: write masking, read selection and memory-attribute routing.
`timescale 1ns / 1ps

module nbcfg_decode
   import nbcfg_pkg::*;
(
   input  req_type    req,
   input  logic       fire,
   input  logic [7:0] rd_byte,
   input  logic [7:0] shadow_cd,
   input  logic [7:0] shadow_ef,
   input  logic [7:0] smram_ctl,
   output wr_type     wr,
   output rsp_type    rsp
);

   logic       fn_ok;
   logic [1:0] pair;
   logic [2:0] blk;

   assign fn_ok = (req.function_number == FUNC_ZERO);
   assign blk = req.mem_address[16:14];

   always_comb begin
      wr.en = 1'b0;
      wr.idx = req.register_index;
      wr.data = req.write_data;
      if (req.register_index == REG_STATUS_HI) begin
         wr.data = rd_byte & ~(req.write_data & STATUS_W1C_MASK);
      end
      if (fire && req.operation == OP_WRITE && fn_ok &&
          (req.register_index == REG_STATUS_HI || cfg_writable(req.register_index))) begin
         wr.en = 1'b1;
      end
   end

   always_comb begin
      rsp = '0;
      pair = req.mem_address[16] ? shadow_ef[7:6] : shadow_ef[3:2];
      case (req.operation)
         OP_READ: begin
            rsp.read_data = fn_ok ? rd_byte : 8'hff;
         end
         OP_QUERY: begin
            if (req.mem_address >= 20'ha0000) begin
               rsp.region_claimed = 1'b1;
               if (req.mem_address[19:17] == 3'b101) begin
                  if (req.in_smm || smram_ctl[4]) begin
                     rsp.read_route = ROUTE_INT;
                     rsp.write_route = WROUTE_INT;
                  end
               end else if (req.mem_address[19:17] == 3'b110) begin
                  if (shadow_cd[blk]) begin
                     rsp.read_route = ROUTE_INT;
                     rsp.write_route = WROUTE_INT;
                  end
               end else if (pair[0]) begin
                  rsp.read_route = ROUTE_INT;
                  rsp.write_route = pair[1] ? WROUTE_DISCARD : WROUTE_INT;
               end
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

### rtl/core/northbridge_config_and_shadow_decode.sv
// Top level of the northbridge configuration space and shadow-memory decode block.
//
// Requests arrive on the req_ stream: tuser carries the operation (read, write or
// memory-attribute query) and tdata the access fields. Every request item gives
// exactly one response item on the rsp_ stream, in order.
// An accepted item is registered, its configuration byte is read from the
// 256-entry store at the same edge, and the result is registered in the output
// register when the item advances, and the response is presented from there.
// One item is accepted every cycle while rsp_tready stays high; the limit is the
// single read and single write port of the byte store.
// A write to a byte is forwarded to a read of the same byte that follows at once.
// Reset restores the identification and class defaults at once through per-byte
// valid flags; no clearing pass is needed and requests are taken straight away.
// When the receiver holds rsp_tready low, the result and the pending item are
// kept, and req_tready drops only once both registers are full.
`timescale 1ns / 1ps

module northbridge_config_and_shadow_decode
   import nbcfg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // function_number[2:0], register_index[10:3], write_data[18:11],
   // mem_address[38:19], in_smm[39]
   input  logic [39:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], region_claimed[8], read_route[9], write_route[11:10], zero fill
   output logic [15:0] rsp_tdata
);

   req_type    req_in;
   req_type    s1_ff;
   logic       s1_valid_ff, s1_valid_in;
   rsp_type    out_ff;
   logic       out_valid_ff, out_valid_in;
   logic       accept;
   logic       advance;
   wr_type     wr;
   rsp_type    rsp;
   logic [7:0] rd_byte;
   logic [7:0] shadow_cd;
   logic [7:0] shadow_ef;
   logic [7:0] smram_ctl;

   assign req_in.operation = req_tuser;
   assign req_in.function_number = req_tdata[2:0];
   assign req_in.register_index = req_tdata[10:3];
   assign req_in.write_data = req_tdata[18:11];
   assign req_in.mem_address = req_tdata[38:19];
   assign req_in.in_smm = req_tdata[39];

   assign advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept = req_tvalid && req_tready;

   assign s1_valid_in = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   nbcfg_space u_space (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_idx    (req_in.register_index),
      .wr        (wr),
      .rd_byte   (rd_byte),
      .shadow_cd (shadow_cd),
      .shadow_ef (shadow_ef),
      .smram_ctl (smram_ctl)
   );

   nbcfg_decode u_decode (
      .req       (s1_ff),
      .fire      (advance),
      .rd_byte   (rd_byte),
      .shadow_cd (shadow_cd),
      .shadow_ef (shadow_ef),
      .smram_ctl (smram_ctl),
      .wr        (wr),
      .rsp       (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_in;
      end
      if (advance) begin
         out_ff <= rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {4'd0, out_ff};

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request stage empty but not ready");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (advance && s1_ff.operation == OP_WRITE &&
                 s1_ff.function_number == FUNC_ZERO))
      else $error("store written outside a committing function 0 write");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost from the request stage");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result lost on its way to the output register");

endmodule

### tb/tb_northbridge_config_and_shadow_decode.sv
// Self-checking testbench for the northbridge configuration space and shadow decode.
`timescale 1ns / 1ps

module tb_northbridge_config_and_shadow_decode;
   import nbcfg_pkg::*;

   localparam logic [1:0]  OP_NOP        = 2'd3;
   localparam logic [7:0]  REG_VENDOR_LO = 8'h00;
   localparam logic [7:0]  REG_DEVICE_HI = 8'h03;
   localparam logic [7:0]  REG_CLASS     = 8'h0b;
   localparam logic [7:0]  REG_SCRATCH   = 8'h40;
   localparam logic [7:0]  REG_LAST      = 8'hff;
   localparam logic [19:0] SMM_WINDOW_BASE = 20'ha0000;
   localparam logic [19:0] SHADOW_C_BASE = 20'hc0000;
   localparam logic [19:0] SEG_E_BASE    = 20'he0000;
   localparam logic [19:0] SEG_F_BASE    = 20'hf0000;
   localparam int          STALL_LIMIT   = 10000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [7:0]  cfg_bytes [256];
   rsp_type     expected_results [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   logic        steady = 1'b0;

   northbridge_config_and_shadow_decode i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 29);
   end

   task automatic load_defaults();
      for (int i = 0; i < 256; i++) cfg_bytes[i] = 8'h00;
      cfg_bytes[8'h00] = 8'h60;
      cfg_bytes[8'h01] = 8'h10;
      cfg_bytes[8'h02] = 8'h91;
      cfg_bytes[8'h03] = 8'h88;
      cfg_bytes[8'h07] = 8'h02;
      cfg_bytes[8'h08] = 8'h01;
      cfg_bytes[8'h0b] = 8'h06;
   endtask

   function automatic logic is_read_only(input logic [7:0] idx);
      return (idx <= 8'h03) || (idx == 8'h06) || (idx >= 8'h08 && idx <= 8'h0b) ||
             (idx >= 8'h0e && idx <= 8'h3f);
   endfunction

   function automatic void rom_segment(input logic [1:0] pair, output logic rd,
                                       output logic [1:0] wr);
      rd = pair[0] ? ROUTE_INT : ROUTE_EXT;
      wr = !pair[0] ? WROUTE_EXT : (pair[1] ? WROUTE_DISCARD : WROUTE_INT);
   endfunction

   // Updates the configuration copy and queues the response that the item should give.
   task automatic route_and_store(input req_type item);
      rsp_type res;
      res = '0;
      case (item.operation)
         OP_READ: begin
            res.read_data = (item.function_number == FUNC_ZERO) ?
                            cfg_bytes[item.register_index] : 8'hff;
         end
         OP_WRITE: begin
            if (item.function_number == FUNC_ZERO) begin
               if (item.register_index == REG_STATUS_HI)
                  cfg_bytes[REG_STATUS_HI] &= ~(item.write_data & STATUS_W1C_MASK);
               else if (!is_read_only(item.register_index))
                  cfg_bytes[item.register_index] = item.write_data;
            end
         end
         OP_QUERY: begin
            if (item.mem_address >= SMM_WINDOW_BASE) begin
               res.region_claimed = 1'b1;
               if (item.mem_address < SHADOW_C_BASE) begin
                  if (item.in_smm || cfg_bytes[REG_SMRAM][4]) begin
                     res.read_route  = ROUTE_INT;
                     res.write_route = WROUTE_INT;
                  end
               end else if (item.mem_address < SEG_E_BASE) begin
                  if (cfg_bytes[REG_SHADOW_CD][item.mem_address[16:14]]) begin
                     res.read_route  = ROUTE_INT;
                     res.write_route = WROUTE_INT;
                  end
               end else if (item.mem_address < SEG_F_BASE) begin
                  rom_segment(cfg_bytes[REG_SHADOW_EF][3:2], res.read_route, res.write_route);
               end else begin
                  rom_segment(cfg_bytes[REG_SHADOW_EF][7:6], res.read_route, res.write_route);
               end
            end
         end
         default: res = '0;
      endcase
      expected_results.push_back(res);
   endtask

   // Presents one item, with a random gap first outside the steady stretch, and returns at the edge that takes it.
   task automatic send_item(input logic [1:0] op, input logic [2:0] fn, input logic [7:0] idx,
                            input logic [7:0] data, input logic [19:0] addr, input logic smm);
      req_type item;
      item.operation       = op;
      item.function_number = fn;
      item.register_index  = idx;
      item.write_data      = data;
      item.mem_address     = addr;
      item.in_smm          = smm;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {smm, addr, data, idx, fn};
      do @(posedge clock); while (!req_tready);
      route_and_store(item);
   endtask

   task automatic cfg_read(input logic [7:0] idx);
      send_item(OP_READ, FUNC_ZERO, idx, 8'h00, 20'h00000, 1'b0);
   endtask

   task automatic cfg_write(input logic [7:0] idx, input logic [7:0] data);
      send_item(OP_WRITE, FUNC_ZERO, idx, data, 20'h00000, 1'b0);
   endtask

   task automatic mem_query(input logic [19:0] addr, input logic smm);
      send_item(OP_QUERY, FUNC_ZERO, 8'h00, 8'h00, addr, smm);
   endtask

   task automatic test_reset_defaults();
      cfg_read(REG_VENDOR_LO);
      cfg_read(REG_STATUS_HI);
      cfg_read(REG_CLASS);
   endtask

   task automatic test_write_protection();
      cfg_write(REG_VENDOR_LO, 8'hff);
      cfg_read(REG_VENDOR_LO);
      cfg_write(REG_SCRATCH, 8'ha5);
      cfg_read(REG_SCRATCH);
      cfg_write(REG_LAST, 8'h5a);
   endtask

   task automatic test_status_clear();
      cfg_write(REG_STATUS_HI, 8'hff);
      cfg_read(REG_STATUS_HI);
   endtask

   task automatic test_other_function();
      send_item(OP_READ, 3'd7, REG_VENDOR_LO, 8'h00, 20'h00000, 1'b0);
      send_item(OP_WRITE, 3'd7, REG_SMRAM, 8'hff, 20'h00000, 1'b0);
   endtask

   task automatic test_smram_window();
      mem_query(SMM_WINDOW_BASE, 1'b0);
      mem_query(20'hbffff, 1'b1);
      cfg_write(REG_SMRAM, 8'h10);
      mem_query(SMM_WINDOW_BASE, 1'b0);
   endtask

   task automatic test_shadow_blocks();
      cfg_write(REG_SHADOW_CD, 8'h81);
      mem_query(SHADOW_C_BASE, 1'b0);
      mem_query(20'hdffff, 1'b0);
      mem_query(20'hc4000, 1'b0);
   endtask

   task automatic test_rom_segments();
      cfg_write(REG_SHADOW_EF, 8'hc4);
      mem_query(SEG_E_BASE, 1'b0);
      mem_query(20'hfffff, 1'b1);
      mem_query(20'h9ffff, 1'b1);
      mem_query(20'h00000, 1'b0);
   endtask

   task automatic test_unused_op();
      send_item(OP_NOP, 3'd7, 8'hff, 8'hff, 20'hfffff, 1'b1);
   endtask

   // Mostly function-0 traffic on the status and routing registers and queries into the
   // controlled area, with a stretch where neither side pauses.
   task automatic test_random_traffic();
      logic [1:0]  op;
      logic [2:0]  fn;
      logic [7:0]  idx;
      logic [19:0] addr;
      int          pick;
      for (int n = 0; n < 900; n++) begin
         steady = (n >= 300 && n < 450);
         pick = $urandom_range(0, 99);
         op = (pick < 30) ? OP_READ : (pick < 60) ? OP_WRITE : (pick < 96) ? OP_QUERY : OP_NOP;
         fn = ($urandom_range(0, 9) < 8) ? FUNC_ZERO : 3'($urandom_range(0, 7));
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: idx = REG_STATUS_HI;
            1: idx = REG_SHADOW_CD;
            2: idx = REG_SHADOW_EF;
            default: idx = REG_SMRAM;
         endcase
         if (pick >= 50) idx = (pick < 70) ? 8'($urandom_range(0, 8'h40)) : 8'($urandom());
         addr = ($urandom_range(0, 99) < 80) ?
                20'($urandom_range(SMM_WINDOW_BASE, 20'hfffff)) : 20'($urandom());
         send_item(op, fn, idx, 8'($urandom()), addr, 1'($urandom()));
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[11:0]);
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response item, expected none actual %h", $realtime,
                     rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got.read_data !== want.read_data) begin
               error_count++;
               $display("%0t: read_data expected %h actual %h", $realtime,
                        want.read_data, got.read_data);
            end
            if (got.region_claimed !== want.region_claimed) begin
               error_count++;
               $display("%0t: region_claimed expected %b actual %b", $realtime,
                        want.region_claimed, got.region_claimed);
            end
            if (got.read_route !== want.read_route) begin
               error_count++;
               $display("%0t: read_route expected %b actual %b", $realtime,
                        want.read_route, got.read_route);
            end
            if (got.write_route !== want.write_route) begin
               error_count++;
               $display("%0t: write_route expected %0d actual %0d", $realtime,
                        want.write_route, got.write_route);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      load_defaults();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_write_protection();
      test_status_clear();
      test_other_function();
      test_smram_window();
      test_shadow_blocks();
      test_rom_segments();
      test_unused_op();
      test_random_traffic();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/nbcfg_pkg.sv
rtl/core/nbcfg_space.sv
rtl/core/nbcfg_decode.sv
rtl/core/northbridge_config_and_shadow_decode.sv
tb/tb_northbridge_config_and_shadow_decode.sv
